// ===== hw/rtl/nfa_string_matcher_assert.svh =====
// assertion macros for the string matcher, clocked on i_clk, off during reset
`ifndef NFA_STRING_MATCHER_ASSERT_SVH
`define NFA_STRING_MATCHER_ASSERT_SVH

// same-cycle implication
`define NSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nsm check failed");

// next-cycle implication
`define NSM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nsm check failed");

`endif

// ===== hw/rtl/nsm_pkg.sv =====
`default_nettype none
package nsm_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 7;
    localparam int STATE_W  = 6;
    localparam int SYM_W    = 8;
    localparam int SCOUNT_W = 7;
    localparam int TCOUNT_W = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
    localparam logic [OP_W-1:0] OP_CHAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_ACCEPT = 2'd1;
    localparam logic [1:0] REG_SCOUNT = 2'd2;
    localparam logic [1:0] REG_TCOUNT = 2'd3;

    typedef struct packed {
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   symbol;
        logic               is_epsilon;
    } t_edge;

    typedef struct packed {
        logic [STATE_W-1:0]  start_state;
        logic [STATE_W-1:0]  accept_state;
        logic [SCOUNT_W-1:0] num_states;
        logic [TCOUNT_W-1:0] num_edges;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic matched;
        logic alive;
    } t_res;

endpackage
`default_nettype wire

// ===== hw/rtl/nsm_in_if.sv =====
`default_nettype none
interface nsm_in_if;
    import nsm_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [IDX_W-1:0]   entry_index;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   entry_symbol;
    logic               entry_is_epsilon;
    logic [SYM_W-1:0]   character;

    modport source (
        output valid, opcode, entry_index, from_state, to_state, entry_symbol,
               entry_is_epsilon, character,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, from_state, to_state, entry_symbol,
               entry_is_epsilon, character,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/nsm_out_if.sv =====
`default_nettype none
interface nsm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic alive;

    modport source (output valid, matched, alive, input ready);
    modport sink (input valid, matched, alive, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/nsm_table.sv =====
`default_nettype none
module nsm_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  nsm_pkg::t_edge     i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output nsm_pkg::t_edge     o_rd_data
);
    import nsm_pkg::*;

    t_edge r_mem [0:DEPTH-1];
    t_edge r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== hw/rtl/nsm_engine.sv =====
`default_nettype none
module nsm_engine #(
    parameter int MAX_STATES      = 64,
    parameter int MAX_TRANSITIONS = 128,
    parameter int AW              = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [nsm_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [nsm_pkg::SYM_W-1:0]   i_character,
    input  nsm_pkg::t_cfg                    i_cfg,
    output logic                             o_idle,
    output logic                             o_rd_en,
    output logic [AW-1:0]                    o_rd_addr,
    input  nsm_pkg::t_edge                   i_rd_data,
    output nsm_pkg::t_res                    o_res,
    input  wire logic                        i_res_take
);
    import nsm_pkg::*;

    localparam int SIDX_W = $clog2(MAX_STATES);
    localparam int NSW    = $clog2(MAX_STATES + 1);
    localparam int NCW    = (NSW > SCOUNT_W) ? NSW : SCOUNT_W;
    localparam int CNT_W  = $clog2(MAX_TRANSITIONS + 1);
    localparam int ECW    = (CNT_W > TCOUNT_W) ? CNT_W : TCOUNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MOVE  = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_addr, n_addr;
    logic                  r_rd_vld;
    logic                  r_changed, n_changed;
    logic [SYM_W-1:0]      r_chr, n_chr;
    logic [MAX_STATES-1:0] r_cur, n_cur;
    logic [MAX_STATES-1:0] r_set, n_set;

    logic [NCW-1:0]        w_ns;
    logic [ECW-1:0]        w_ne;
    logic                  w_scan, w_issue, w_pass_end;
    logic                  w_from_ok, w_to_ok;
    logic [SIDX_W-1:0]     w_fi, w_ti;
    logic                  w_move_hit, w_close_hit;
    logic [MAX_STATES-1:0] w_mask;

    // counts saturate at the capacity
    assign w_ns = (NCW'(i_cfg.num_states) > NCW'(MAX_STATES)) ?
                  NCW'(MAX_STATES) : NCW'(i_cfg.num_states);
    assign w_ne = (ECW'(i_cfg.num_edges) > ECW'(MAX_TRANSITIONS)) ?
                  ECW'(MAX_TRANSITIONS) : ECW'(i_cfg.num_edges);

    assign w_scan     = (r_state == ST_MOVE) || (r_state == ST_CLOSE);
    assign w_issue    = w_scan && (ECW'(r_addr) < w_ne);
    // pass is over once every entry was read and the last one processed
    assign w_pass_end = w_scan && !w_issue && !r_rd_vld;

    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_addr[AW-1:0];

    assign w_from_ok = NCW'(i_rd_data.from_state) < w_ns;
    assign w_to_ok   = NCW'(i_rd_data.to_state) < w_ns;
    assign w_fi      = SIDX_W'(i_rd_data.from_state);
    assign w_ti      = SIDX_W'(i_rd_data.to_state);

    assign w_move_hit = r_rd_vld && (r_state == ST_MOVE) && !i_rd_data.is_epsilon &&
                        (i_rd_data.symbol == r_chr) && w_from_ok && w_to_ok && r_cur[w_fi];
    assign w_close_hit = r_rd_vld && (r_state == ST_CLOSE) && i_rd_data.is_epsilon &&
                         w_from_ok && w_to_ok && r_set[w_fi] && !r_set[w_ti];

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_changed = r_changed;
        n_chr     = r_chr;
        n_cur     = r_cur;
        n_set     = r_set;
        if (w_issue) begin
            n_addr = r_addr + CNT_W'(1);
        end
        if (w_move_hit || w_close_hit) begin
            n_set[w_ti] = 1'b1;
        end
        if (w_close_hit) begin
            n_changed = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_chr     = i_character;
                    n_addr    = '0;
                    n_changed = 1'b0;
                    unique case (i_opcode)
                        OP_BEGIN: begin
                            n_set = '0;
                            if (NCW'(i_cfg.start_state) < w_ns) begin
                                n_set[SIDX_W'(i_cfg.start_state)] = 1'b1;
                            end
                            n_state = ST_CLOSE;
                        end
                        OP_CHAR: begin
                            n_set   = '0;
                            n_state = ST_MOVE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOVE: begin
                if (w_pass_end) begin
                    n_state   = ST_CLOSE;
                    n_addr    = '0;
                    n_changed = 1'b0;
                end
            end
            ST_CLOSE: begin
                if (w_pass_end) begin
                    if (r_changed) begin
                        n_addr    = '0;
                        n_changed = 1'b0;
                    end else begin
                        n_cur   = r_set;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_changed <= 1'b0;
            r_cur     <= '0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_rd_vld  <= w_issue;
            r_changed <= n_changed;
            r_cur     <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chr <= n_chr;
        r_set <= n_set;
    end

    // states at or beyond the live count read as inactive
    always_comb begin
        for (int s = 0; s < MAX_STATES; s++) begin
            w_mask[s] = NCW'(s) < w_ns;
        end
    end

    assign o_idle        = (r_state == ST_IDLE);
    assign o_res.valid   = (r_state == ST_DONE);
    assign o_res.alive   = |(r_cur & w_mask);
    assign o_res.matched = (NCW'(i_cfg.accept_state) < w_ns) &&
                           r_cur[SIDX_W'(i_cfg.accept_state)];

endmodule
`default_nettype wire

// ===== hw/rtl/nfa_string_matcher.sv =====
// nfa_string_matcher: runs a nondeterministic automaton with empty moves over a byte stream
//
// i_in carries one item per transfer: opcode 0 writes a transition table entry,
// opcode 1 starts a string at the closure of start_state, opcode 2 consumes one byte.
// o_out returns one transfer per item: matched (accept state active) and alive.
// configuration goes through the apb port (start, accept, state count, transition
// count at byte addresses 0, 4, 8, 12) and is to be written by the user only while
// no item is in flight; the block itself does not enforce this.
// one item is taken at a time. a write or unused opcode goes from idle straight to the
// done state and then to the output register. begin and character items scan the
// table memory in passes over its first N entries, N the live transition count: a
// begin item runs P changing closure passes and a last unchanged one, a character
// item one move pass more before them, for P bounded by the state count. the table
// has a single read port and a registered read, so each pass reads its entries in turn.
//
// reset clears the control and configuration registers and the active set; table
// entries are undefined until written. the result sits in an output register, so a
// stalled receiver holds the result while the next item is accepted and worked on;
// that item then waits to hand over its own result.
`default_nettype none
module nfa_string_matcher #(
    parameter int MAX_STATES      = 64,
    parameter int MAX_TRANSITIONS = 128
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    nsm_in_if.sink                           i_in,
    nsm_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [nsm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [nsm_pkg::DATA_W-1:0]  pwdata,
    output logic      [nsm_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import nsm_pkg::*;

    localparam int AW    = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);
    localparam int ECW   = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;

    t_cfg  r_cfg;
    t_edge w_wr_data;
    t_edge w_rd_data;
    t_res  w_res;

    logic          w_cfg_wr;
    logic          w_start;
    logic          w_tbl_wr;
    logic          w_idle;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_take;
    logic          r_out_vld;
    logic          r_matched;
    logic          r_alive;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_START:  r_cfg.start_state  <= pwdata[STATE_W-1:0];
                REG_ACCEPT: r_cfg.accept_state <= pwdata[STATE_W-1:0];
                REG_SCOUNT: r_cfg.num_states   <= pwdata[SCOUNT_W-1:0];
                REG_TCOUNT: r_cfg.num_edges    <= pwdata[TCOUNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START:  prdata = DATA_W'(r_cfg.start_state);
            REG_ACCEPT: prdata = DATA_W'(r_cfg.accept_state);
            REG_SCOUNT: prdata = DATA_W'(r_cfg.num_states);
            REG_TCOUNT: prdata = DATA_W'(r_cfg.num_edges);
        endcase
    end

    // input side
    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;
    assign w_tbl_wr   = w_start && (i_in.opcode == OP_WRITE) &&
                        (ECW'(i_in.entry_index) < ECW'(MAX_TRANSITIONS));

    assign w_wr_data.from_state = i_in.from_state;
    assign w_wr_data.to_state   = i_in.to_state;
    assign w_wr_data.symbol     = i_in.entry_symbol;
    assign w_wr_data.is_epsilon = i_in.entry_is_epsilon;

    nsm_table #(
        .DEPTH (MAX_TRANSITIONS),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_tbl_wr),
        .i_wr_addr (AW'(i_in.entry_index)),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    nsm_engine #(
        .MAX_STATES      (MAX_STATES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .AW              (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_opcode    (i_in.opcode),
        .i_character (i_in.character),
        .i_cfg       (r_cfg),
        .o_idle      (w_idle),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    // output register
    assign w_take = w_res.valid && (!r_out_vld || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_matched <= w_res.matched;
            r_alive   <= w_res.alive;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.matched = r_matched;
    assign o_out.alive   = r_alive;

endmodule
`default_nettype wire

// ===== hw/rtl/nsm_checker.sv =====
`default_nettype none
`include "nfa_string_matcher_assert.svh"
module nsm_props (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_matched,
    input wire logic i_out_alive
);

    // a stalled result holds
    `NSM_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_matched) && $stable(i_out_alive))

    // the accept state is a live state, so a match implies a live set
    `NSM_ASSERT_IMP(a_match_alive, i_out_valid, !i_out_matched || i_out_alive)

    // one item in flight: the input closes right after a transfer
    `NSM_ASSERT_NXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready)

    // a new result only comes from an item that was being worked on
    `NSM_ASSERT_IMP(a_result_source, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind nfa_string_matcher nsm_props u_nsm_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_matched (o_out.matched),
    .i_out_alive   (o_out.alive)
);
`default_nettype wire
